FILE: design/sds_pkg.sv
// Shared types and constants for the SCAN disk scheduler.
// Depends on nothing; imported by every module of the block.
`timescale 1ns / 1ps

package sds_pkg;

	localparam int TRACK_BITS = 16;
	localparam int COUNT_BITS = TRACK_BITS + 1;
	localparam int STEP_BITS  = 16;
	localparam int SUM_BITS   = 22;
	localparam int ADDR_BITS  = 4;
	localparam int DATA_BITS  = 32;

	localparam logic [SUM_BITS-1:0]   SUM_MAX     = {SUM_BITS{1'b1}};
	localparam logic [COUNT_BITS-1:0] TRACK_LIMIT = {1'b1, {TRACK_BITS{1'b0}}};
	localparam logic [COUNT_BITS-1:0] TC_RESET    = 17'd200;

	// Register indexes (byte address / 4)
	localparam logic [1:0] REG_TRACK_COUNT = 2'd0;
	localparam logic [1:0] REG_START_TRACK = 2'd1;
	localparam logic [1:0] REG_START_LEFT  = 2'd2;

	typedef logic [TRACK_BITS-1:0] track_t;

	typedef struct packed {
		track_t request_track;
		logic   final_request;
	} req_t;

	typedef struct packed {
		track_t                served_track;
		logic [STEP_BITS-1:0]  seek_step;
		logic [SUM_BITS-1:0]   seek_total;
		logic                  end_of_order;
	} res_t;

	// Queue entry between front and back
	typedef struct packed {
		track_t track;
		logic   keep;   // in range, worth storing
		logic   last;   // closes the batch
	} qent_t;

	// Sanitized configuration
	typedef struct packed {
		logic [COUNT_BITS-1:0] tracks;      // clamped to 1..2^TRACK_BITS
		track_t                last_track;  // tracks - 1
		track_t                head;        // start head, clamped below tracks
		logic                  left;
	} cfg_t;

endpackage

FILE: design/scan_disk_scheduler.sv
// SCAN disk scheduler: requests load at one per cycle through a 2-entry queue, stalled while a batch is served.
// After the final request, each result costs one scan of the N stored requests,
// plus one more scan for the turn.
// Reset: registers to 200/0/0, queue and store count empty, no clearing pass.
`timescale 1ns / 1ps

module scan_disk_scheduler #(
	parameter int MAX_REQUESTS = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [sds_pkg::ADDR_BITS-1:0]   paddr,
	input  logic [sds_pkg::DATA_BITS-1:0]   pwdata,
	output logic [sds_pkg::DATA_BITS-1:0]   prdata,
	output logic                            pready,
	input  logic                            req_valid,
	output logic                            req_stall,
	input  sds_pkg::req_t                   req_data,
	output logic                            res_valid,
	input  logic                            res_stall,
	output sds_pkg::res_t                   res_data
);
	import sds_pkg::*;

	logic [COUNT_BITS-1:0] track_count_q;
	track_t                start_track_q;
	logic                  start_left_q;
	logic                  cfg_wr;
	logic [1:0]            reg_idx;
	logic [COUNT_BITS-1:0] tc_eff;
	logic [COUNT_BITS-1:0] tc_m1;
	cfg_t                  cfg;
	logic                  q_pop;
	logic                  q_empty;
	qent_t                 q_data;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign cfg_wr  = psel && penable && pwrite;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			track_count_q <= TC_RESET;
			start_track_q <= '0;
			start_left_q  <= 1'b0;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_TRACK_COUNT: track_count_q <= pwdata[COUNT_BITS-1:0];
				REG_START_TRACK: start_track_q <= pwdata[TRACK_BITS-1:0];
				REG_START_LEFT:  start_left_q  <= pwdata[0];
				default: ;
			endcase
		end
	end

	// register reads
	always_comb begin
		unique case (reg_idx)
			REG_TRACK_COUNT: prdata = DATA_BITS'(track_count_q);
			REG_START_TRACK: prdata = DATA_BITS'(start_track_q);
			REG_START_LEFT:  prdata = DATA_BITS'(start_left_q);
			default:         prdata = '0;
		endcase
	end

	// clamp track count and start head into legal range
	always_comb begin
		if (track_count_q == '0)              tc_eff = COUNT_BITS'(1);
		else if (track_count_q > TRACK_LIMIT) tc_eff = TRACK_LIMIT;
		else                                  tc_eff = track_count_q;
		tc_m1          = tc_eff - 1'b1;
		cfg.tracks     = tc_eff;
		cfg.last_track = tc_m1[TRACK_BITS-1:0];
		cfg.head       = ({1'b0, start_track_q} >= tc_eff) ? tc_m1[TRACK_BITS-1:0]
		                                                    : start_track_q;
		cfg.left       = start_left_q;
	end

	sds_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_data (req_data),
		.tracks   (tc_eff),
		.pop      (q_pop),
		.pop_data (q_data),
		.empty    (q_empty)
	);

	sds_back #(
		.MAX_REQUESTS(MAX_REQUESTS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.q_empty  (q_empty),
		.q_data   (q_data),
		.q_pop    (q_pop),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res_data (res_data)
	);

endmodule

FILE: design/sds_queue.sv
// Two-entry request queue between the scheduler front and back.
// Depends on sds_pkg for the entry type.
`timescale 1ns / 1ps

module sds_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  sds_pkg::qent_t push_data,
	input  logic          pop,
	output sds_pkg::qent_t pop_data,
	output logic          full,
	output logic          empty
);
	import sds_pkg::*;

	qent_t       slot_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  fill_q;

	assign full     = fill_q == 2'd2;
	assign empty    = fill_q == 2'd0;
	assign pop_data = slot_q[rd_ptr_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop)      fill_q <= fill_q + 2'd1;
			else if (!push && pop) fill_q <= fill_q - 2'd1;
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= push_data;
	end

endmodule

FILE: design/sds_front.sv
// Scheduler front: accepts requests, range-checks them and queues them.
// Depends on sds_pkg and sds_queue.
`timescale 1ns / 1ps

module sds_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             req_valid,
	output logic                             req_stall,
	input  sds_pkg::req_t                    req_data,
	input  logic [sds_pkg::COUNT_BITS-1:0]   tracks,
	input  logic                             pop,
	output sds_pkg::qent_t                   pop_data,
	output logic                             empty
);
	import sds_pkg::*;

	logic  full;
	logic  push;
	qent_t push_data;

	// accept whenever the queue has room
	assign req_stall = full;
	assign push      = req_valid && !full;

	// classify: out-of-range tracks are marked to be dropped
	always_comb begin
		push_data.track = req_data.request_track;
		push_data.keep  = {1'b0, req_data.request_track} < tracks;
		push_data.last  = req_data.final_request;
	end

	sds_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.pop      (pop),
		.pop_data (pop_data),
		.full     (full),
		.empty    (empty)
	);

endmodule

FILE: design/sds_back.sv
// Scheduler back: stores the batch and runs one selection scan per result.
// Depends on sds_pkg; owns the request store and the result register.
`timescale 1ns / 1ps

module sds_back #(
	parameter int MAX_REQUESTS = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  sds_pkg::cfg_t  cfg,
	input  logic           q_empty,
	input  sds_pkg::qent_t q_data,
	output logic           q_pop,
	output logic           res_valid,
	input  logic           res_stall,
	output sds_pkg::res_t  res_data
);
	import sds_pkg::*;

	localparam int CNT_BITS = $clog2(MAX_REQUESTS + 1);
	localparam int IDX_BITS = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
	localparam logic [CNT_BITS-1:0] CNT_MAX = CNT_BITS'(MAX_REQUESTS);

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_START  = 5'b00010,
		S_SEL    = 5'b00100,
		S_SCAN   = 5'b01000,
		S_DECIDE = 5'b10000
	} state_t;

	state_t              state_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic [CNT_BITS-1:0] idx_q;
	logic                found_q;
	logic                left_q;
	logic                phase_q;
	logic                res_valid_q;
	logic                rdv_s1;

	track_t              store_q [MAX_REQUESTS];
	track_t              rd_s1;
	track_t              bound_q;
	track_t              best_q;
	res_t                pend_q;
	res_t                res_q;

	logic                wr_en;
	logic                rd_en;
	logic                out_free;
	logic                take;
	logic                end_ok;
	logic                adv;
	logic                turn;
	logic                fin;
	logic [STEP_BITS-1:0] step;
	logic [SUM_BITS:0]   sum_w;
	logic [SUM_BITS-1:0] total;

	assign res_valid = res_valid_q;
	assign res_data  = res_q;
	assign out_free  = !res_valid_q || !res_stall;

	// load side: pop in idle, store in-range requests while room remains
	assign q_pop = (state_q == S_IDLE) && !q_empty;
	assign wr_en = q_pop && q_data.keep && (cnt_q < CNT_MAX);
	assign rd_en = (state_q == S_SCAN) && (idx_q < cnt_q);

	// far end joins only the first sweep, and only past the bound
	assign end_ok = !phase_q && (left_q ? (bound_q != '0) : (cfg.last_track > bound_q));

	// nearest candidate strictly beyond the bound in the sweep direction
	assign take = rdv_s1
		&& (left_q ? (rd_s1 < bound_q) : (rd_s1 > bound_q))
		&& (!found_q || (left_q ? (rd_s1 > best_q) : (rd_s1 < best_q)));

	assign adv  = (state_q == S_DECIDE) && found_q && out_free;
	assign turn = (state_q == S_DECIDE) && !found_q && !phase_q;
	assign fin  = (state_q == S_DECIDE) && !found_q && phase_q && out_free;

	// seek distance and saturating running total
	assign step  = (best_q > pend_q.served_track) ? (best_q - pend_q.served_track)
	                                               : (pend_q.served_track - best_q);
	assign sum_w = {1'b0, pend_q.seek_total} + (SUM_BITS + 1)'(step);
	assign total = sum_w[SUM_BITS] ? SUM_MAX : sum_w[SUM_BITS-1:0];

	// request store, registered read
	always_ff @(posedge clk) begin
		if (wr_en) store_q[cnt_q[IDX_BITS-1:0]] <= q_data.track;
		if (rd_en) rd_s1 <= store_q[idx_q[IDX_BITS-1:0]];
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			idx_q       <= '0;
			found_q     <= 1'b0;
			left_q      <= 1'b0;
			phase_q     <= 1'b0;
			res_valid_q <= 1'b0;
			rdv_s1      <= 1'b0;
		end else begin
			rdv_s1 <= rd_en;
			if (adv || fin)      res_valid_q <= 1'b1;
			else if (!res_stall) res_valid_q <= 1'b0;
			if (wr_en) cnt_q <= cnt_q + 1'b1;

			unique case (state_q)
				S_IDLE: begin
					if (q_pop && q_data.last) state_q <= S_START;
				end
				S_START: begin
					left_q  <= cfg.left;
					phase_q <= 1'b0;
					state_q <= S_SEL;
				end
				S_SEL: begin
					idx_q   <= '0;
					found_q <= end_ok;
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (rd_en) idx_q <= idx_q + 1'b1;
					if (take)  found_q <= 1'b1;
					if (!rd_en && !rdv_s1) state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					if (adv) begin
						state_q <= S_SEL;
					end else if (turn) begin
						phase_q <= 1'b1;
						left_q  <= ~left_q;
						state_q <= S_SEL;
					end else if (fin) begin
						cnt_q   <= '0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath: bound, best candidate, pending result, output register
	always_ff @(posedge clk) begin
		if (state_q == S_START) begin
			bound_q              <= cfg.head;
			pend_q.served_track  <= cfg.head;
			pend_q.seek_step     <= '0;
			pend_q.seek_total    <= '0;
			pend_q.end_of_order  <= 1'b0;
		end
		if (state_q == S_SEL) best_q <= left_q ? '0 : cfg.last_track;
		if (take) best_q <= rd_s1;
		if (adv) begin
			res_q               <= pend_q;
			pend_q.served_track <= best_q;
			pend_q.seek_step    <= step;
			pend_q.seek_total   <= total;
			bound_q             <= best_q;
		end
		if (turn) bound_q <= cfg.head;
		// last result of the batch carries the end mark
		if (fin) begin
			res_q <= {pend_q.served_track, pend_q.seek_step, pend_q.seek_total, 1'b1};
		end
	end

	// a chosen track always lies strictly past the bound
	a_best_beyond: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DECIDE && found_q) |->
			(left_q ? (best_q < bound_q) : (best_q > bound_q)))
		else $error("selected track not beyond sweep bound");

	// closing a batch leaves the final result out and the store empty
	a_batch_close: assert property (@(posedge clk) disable iff (!arst_n)
		fin |=> (state_q == S_IDLE && cnt_q == '0 && res_valid_q && res_q.end_of_order))
		else $error("batch did not close cleanly");

	// store reads only return during a scan
	a_read_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rdv_s1 |-> (state_q == S_SCAN && $past(state_q) == S_SCAN))
		else $error("store read outside scan");

	// fill count never passes the store depth
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> (cnt_q <= CNT_MAX && cnt_q != '0))
		else $error("request count overflow");

endmodule

FILE: verif/tb_scan_disk_scheduler.sv
// Self-checking testbench for scan_disk_scheduler: request batches in, SCAN service order out.
// Depends on sds_pkg (payload types, register indexes, limits) and the scheduler RTL.
`timescale 1ns / 1ps

module tb_scan_disk_scheduler;
	import sds_pkg::*;

	localparam int STORE_DEPTH = 32;
	localparam int HOLD_OFF    = 60;
	localparam int CYCLE_LIMIT = 400000;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 psel, penable, pwrite;
	logic [ADDR_BITS-1:0] paddr;
	logic [DATA_BITS-1:0] pwdata;
	logic [DATA_BITS-1:0] prdata;
	logic                 pready;
	logic                 req_valid, req_stall;
	req_t                 req_data;
	logic                 res_valid, res_stall;
	res_t                 res_data;

	scan_disk_scheduler u_top (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
		.res_valid(res_valid), .res_stall(res_stall), .res_data(res_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Scheduler copy: configuration and the batch being collected
	logic [COUNT_BITS-1:0] cfg_tracks = TC_RESET;
	track_t                cfg_start  = '0;
	logic                  cfg_left   = 1'b0;
	int                    batch_tracks[0:STORE_DEPTH-1];
	int                    batch_count = 0;

	req_t request_queue[$];
	res_t visit_queue[$];
	int   send_idle_pct = 0;
	int   recv_stall_pct = 0;
	bit   req_taken = 1'b0;
	int   mismatch_count = 0;
	int   cycle_count = 0;

	// Load one request; on the final one, build the sweep and queue its visits
	task automatic schedule_request(input req_t r);
		int   tc, head, t, n, nb, i, j, pos, p, k, h, step, sum;
		int   pts[0:STORE_DEPTH+1];
		int   route[0:STORE_DEPTH+1];
		res_t v;
		tc = cfg_tracks;
		if (tc < 1) tc = 1;
		if (tc > 65536) tc = 65536;
		t = r.request_track;
		if (t < tc && batch_count < STORE_DEPTH) begin
			batch_tracks[batch_count] = t;
			batch_count++;
		end
		if (r.final_request) begin
			head = cfg_start;
			if (head >= tc) head = tc - 1;
			// sorted, duplicate-free track set; index -1 is the disk end in the start direction
			n = 0;
			for (i = -1; i < batch_count; i++) begin
				if (i < 0) t = cfg_left ? 0 : tc - 1;
				else t = batch_tracks[i];
				if (t == head) continue;
				pos = 0;
				while (pos < n && pts[pos] < t) pos++;
				if (pos < n && pts[pos] == t) continue;
				for (j = n; j > pos; j--) pts[j] = pts[j-1];
				pts[pos] = t;
				n++;
			end
			nb = 0;
			while (nb < n && pts[nb] < head) nb++;
			// first sweep in the start direction, then the reverse sweep
			k = 0;
			for (p = 0; p < 2; p++) begin
				if (cfg_left ^ p[0]) begin
					for (i = nb - 1; i >= 0; i--) begin
						route[k] = pts[i];
						k++;
					end
				end else begin
					for (i = nb; i < n; i++) begin
						route[k] = pts[i];
						k++;
					end
				end
			end
			v.served_track = track_t'(head);
			v.seek_step    = '0;
			v.seek_total   = '0;
			v.end_of_order = (n == 0);
			visit_queue.insert(visit_queue.size(), v);
			h = head;
			sum = 0;
			for (i = 0; i < n; i++) begin
				step = route[i] > h ? route[i] - h : h - route[i];
				sum += step;
				if (sum > SUM_MAX) sum = SUM_MAX;
				h = route[i];
				v.served_track = track_t'(route[i]);
				v.seek_step    = step[STEP_BITS-1:0];
				v.seek_total   = sum[SUM_BITS-1:0];
				v.end_of_order = (i == n - 1);
				visit_queue.insert(visit_queue.size(), v);
			end
			batch_count = 0;
		end
	endtask

	// Request driver: holds a payload until taken, may idle between requests
	always @(negedge clk) begin
		if (!req_valid || req_taken) begin
			req_taken = 1'b0;
			if (request_queue.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				req_data  <= request_queue.pop_front();
				req_valid <= 1'b1;
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// Result side back-pressure
	always @(negedge clk) begin
		res_stall <= ($urandom_range(0, 99) < recv_stall_pct);
	end

	// Monitor: predicts on accepted requests, checks accepted results
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("CHECKS FAILED");
			$finish;
		end else begin
			if (req_valid && !req_stall) begin
				schedule_request(req_data);
				req_taken = 1'b1;
			end
			if (res_valid && !res_stall) begin
				if (visit_queue.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("unexpected result: track %0d step %0d total %0d end %0b",
							res_data.served_track, res_data.seek_step,
							res_data.seek_total, res_data.end_of_order);
				end else begin
					res_t e;
					e = visit_queue.pop_front();
					if (res_data.served_track !== e.served_track ||
					    res_data.seek_step !== e.seek_step ||
					    res_data.seek_total !== e.seek_total ||
					    res_data.end_of_order !== e.end_of_order) begin
						mismatch_count++;
						if (mismatch_count <= 10) begin
							$write("mismatch: exp track %0d step %0d total %0d end %0b, ",
								e.served_track, e.seek_step, e.seek_total, e.end_of_order);
							$display("got track %0d step %0d total %0d end %0b",
								res_data.served_track, res_data.seek_step,
								res_data.seek_total, res_data.end_of_order);
						end
					end
				end
			end
		end
	end

	task automatic queue_request(input int track, input bit last);
		req_t r;
		r.request_track = track_t'(track);
		r.final_request = last;
		request_queue.insert(request_queue.size(), r);
	endtask

	// APB write: setup cycle, then access cycle
	task automatic write_reg(input logic [1:0] idx, input logic [DATA_BITS-1:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_TRACK_COUNT: cfg_tracks = value[COUNT_BITS-1:0];
			REG_START_TRACK: cfg_start  = value[TRACK_BITS-1:0];
			REG_START_LEFT:  cfg_left   = value[0];
			default: ;
		endcase
	endtask

	task automatic set_disk(input int tc, input int st, input bit left);
		write_reg(REG_TRACK_COUNT, tc);
		write_reg(REG_START_TRACK, st);
		write_reg(REG_START_LEFT, DATA_BITS'(left));
	endtask

	// Wait until every request is taken and every visit has come back
	task automatic wait_drained();
		while (request_queue.size() != 0 || req_valid || visit_queue.size() != 0)
			@(posedge clk);
		repeat (HOLD_OFF) @(posedge clk);
	endtask

	// Random track, biased toward the disk range, the head and the ends
	function automatic int pick_track(input int tc, input int head);
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 70) return $urandom_range(0, tc - 1);
		if (roll < 80) return head;
		if (roll < 88) return ($urandom_range(0, 1) != 0) ? tc - 1 : 0;
		return $urandom_range(0, 65535);
	endfunction

	initial begin
		int ph, tc, st, tc_eff, head_eff, loaded, len, k, t;
		bit left;
		arst_n    = 1'b0;
		psel      = 1'b0;
		penable   = 1'b0;
		pwrite    = 1'b0;
		paddr     = '0;
		pwdata    = '0;
		req_valid = 1'b0;
		req_data  = '0;
		res_stall = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset settings: lone request on the head, then out-of-range,
		// duplicates and a request on the far end track
		queue_request(0, 1'b1);
		queue_request(199, 1'b0);
		queue_request(250, 1'b0);
		queue_request(50, 1'b0);
		queue_request(50, 1'b0);
		queue_request(10, 1'b0);
		queue_request(200, 1'b0);
		queue_request(100, 1'b1);
		wait_drained();

		// Largest disk, head on the last track: no end track, only the reverse sweep
		set_disk(65536, 65535, 1'b0);
		queue_request(0, 1'b0);
		queue_request(65535, 1'b0);
		queue_request(16'hAAAA, 1'b0);
		queue_request(16'h5555, 1'b1);
		wait_drained();

		// Zero track count acts as one track; start head clamps to zero
		set_disk(0, 5, 1'b1);
		queue_request(1, 1'b0);
		queue_request(0, 1'b1);
		wait_drained();

		// Oversized track count clamps; request equal to the left end track
		set_disk(131071, 30000, 1'b1);
		queue_request(40000, 1'b0);
		queue_request(20000, 1'b0);
		queue_request(30000, 1'b0);
		queue_request(0, 1'b1);
		wait_drained();

		set_disk(200, 150, 1'b0);
		queue_request(170, 1'b0);
		queue_request(120, 1'b0);
		queue_request(199, 1'b1);
		wait_drained();

		// Random phases: new disk setting and idle pattern each time
		for (ph = 0; ph < 10; ph++) begin
			case (ph)
				0: begin tc = 65536; st = $urandom_range(0, 65535); left = 1'b0; end
				1: begin tc = $urandom_range(2, 400); st = $urandom_range(0, tc + 3); left = 1'b1; end
				2: begin tc = 1; st = $urandom_range(0, 3); left = $urandom_range(0, 1); end
				3: begin tc = 131071; st = 65535; left = 1'b1; end
				4: begin tc = 65536; st = 0; left = 1'b1; end
				default: begin
					tc = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 131071)
						: $urandom_range(1, 1000);
					st = $urandom_range(0, tc + 2);
					left = $urandom_range(0, 1);
				end
			endcase
			set_disk(tc, st, left);
			tc_eff = (tc < 1) ? 1 : (tc > 65536 ? 65536 : tc);
			head_eff = (st >= tc_eff) ? tc_eff - 1 : st;
			case (ph % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
				default: begin send_idle_pct = 7; recv_stall_pct = 7; end
			endcase
			loaded = 0;
			while (loaded < 4) begin
				// mostly short batches, now and then one that overfills the store
				if (ph == 5 && loaded == 0) len = 36;
				else if ($urandom_range(0, 31) == 0) len = $urandom_range(30, 38);
				else len = $urandom_range(1, 10);
				for (k = 0; k < len; k++) begin
					t = pick_track(tc_eff, head_eff);
					if (t < tc_eff) loaded++;
					queue_request(t, k == len - 1);
				end
			end
			wait_drained();
		end

		if (mismatch_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
